@@ rtl/uofc_pkg.sv @@
`default_nettype none

package uofc_pkg;

    // Field widths
    localparam int ECHO_W  = 15;
    localparam int LEVEL_W = 12;
    localparam int TIME_W  = 32;
    localparam int CM_W    = 9;
    localparam int DIST_W  = 18;
    localparam int HGT_W   = 19;   // exact height before saturation
    localparam int Q8_W    = 18;

    localparam logic [ECHO_W-1:0] ECHO_TIMEOUT_US = 15'd30000;

    // dist_q8 = round(echo * 0.0343 / 2 * 256) = floor(echo * 4.3904 + 1/2).
    // Done as (echo * DIST_MULT + DIST_ROUND) >> DIST_SHIFT with DIST_MULT
    // rounded up; the excess stays below 1/1250 over the echo range, so the
    // floor matches exactly.
    localparam int DIST_SHIFT = 27;
    localparam int DIST_MULT_W = 30;
    localparam int DIST_PROD_W = 46;
    localparam longint unsigned DIST_MULT_L =
        (64'd43904 * (64'd1 << DIST_SHIFT) + 64'd9999) / 64'd10000;
    localparam logic [DIST_MULT_W-1:0] DIST_MULT = DIST_MULT_W'(DIST_MULT_L);
    localparam logic [DIST_PROD_W-1:0] DIST_ROUND = DIST_PROD_W'(64'd1 << (DIST_SHIFT - 1));

    // Q8 output limits, in the exact height width
    localparam logic signed [HGT_W-1:0] Q8_MAX_EXT = 19'sd131071;
    localparam logic signed [HGT_W-1:0] Q8_MIN_EXT = -19'sd131072;

    // Status codes
    typedef enum logic [3:0] {
        ST_NONE    = 4'd0,
        ST_LOSS    = 4'd1,
        ST_FLOOD   = 4'd2,
        ST_INCONS  = 4'd3,
        ST_SOLID   = 4'd4,
        ST_STOPPED = 4'd5,
        ST_BLOCKED = 4'd6,
        ST_ASYM    = 4'd7,
        ST_VEHICLE = 4'd8,
        ST_NORMAL  = 4'd9
    } status_t;

    // Lamp patterns: bit0 green, bit1 yellow, bit2 red
    localparam logic [2:0] LAMP_OFF    = 3'b000;
    localparam logic [2:0] LAMP_GREEN  = 3'b001;
    localparam logic [2:0] LAMP_YELLOW = 3'b010;
    localparam logic [2:0] LAMP_RED    = 3'b100;

    // Register indexes
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_MOUNT     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OBST      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOW       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HIGH      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WATER_THR = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_WATER_DEB = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_PERSIST   = 3'd6;

    // Register reset values
    localparam logic [CM_W-1:0]    RST_MOUNT     = 9'd150;
    localparam logic [CM_W-1:0]    RST_OBST      = 9'd5;
    localparam logic [CM_W-1:0]    RST_LOW       = 9'd50;
    localparam logic [CM_W-1:0]    RST_HIGH      = 9'd100;
    localparam logic [LEVEL_W-1:0] RST_WATER_THR = 12'd2000;
    localparam logic [TIME_W-1:0]  RST_WATER_DEB = 32'd20000;
    localparam logic [TIME_W-1:0]  RST_PERSIST   = 32'd60000;

    typedef struct packed {
        logic [CM_W-1:0]    mount;
        logic [CM_W-1:0]    obst;
        logic [CM_W-1:0]    low;
        logic [CM_W-1:0]    high;
        logic [LEVEL_W-1:0] water_thr;
        logic [TIME_W-1:0]  water_deb;
        logic [TIME_W-1:0]  persist;
    } cfg_t;

    // Word between the distance stage and the classifier
    typedef struct packed {
        logic               hv_one;
        logic               hv_two;
        logic [DIST_W-1:0]  dist_one;
        logic [DIST_W-1:0]  dist_two;
        logic [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]  now;
    } front_t;

    // Result word
    typedef struct packed {
        status_t                  status;
        logic                     green;
        logic                     yellow;
        logic                     red;
        logic signed [Q8_W-1:0]   h_one;
        logic                     hv_one;
        logic signed [Q8_W-1:0]   h_two;
        logic                     hv_two;
        logic                     wet;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/uofc_regs.sv @@
`default_nettype none

module uofc_regs import uofc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t                 cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    // Register writes; values masked to register width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mount     <= RST_MOUNT;
            cfg_reg.obst      <= RST_OBST;
            cfg_reg.low       <= RST_LOW;
            cfg_reg.high      <= RST_HIGH;
            cfg_reg.water_thr <= RST_WATER_THR;
            cfg_reg.water_deb <= RST_WATER_DEB;
            cfg_reg.persist   <= RST_PERSIST;
        end else if (wr_en) begin
            unique case (idx)
                REG_MOUNT:     cfg_reg.mount     <= pwdata[CM_W-1:0];
                REG_OBST:      cfg_reg.obst      <= pwdata[CM_W-1:0];
                REG_LOW:       cfg_reg.low       <= pwdata[CM_W-1:0];
                REG_HIGH:      cfg_reg.high      <= pwdata[CM_W-1:0];
                REG_WATER_THR: cfg_reg.water_thr <= pwdata[LEVEL_W-1:0];
                REG_WATER_DEB: cfg_reg.water_deb <= pwdata;
                REG_PERSIST:   cfg_reg.persist   <= pwdata;
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (idx)
            REG_MOUNT:     prdata = {23'b0, cfg_reg.mount};
            REG_OBST:      prdata = {23'b0, cfg_reg.obst};
            REG_LOW:       prdata = {23'b0, cfg_reg.low};
            REG_HIGH:      prdata = {23'b0, cfg_reg.high};
            REG_WATER_THR: prdata = {20'b0, cfg_reg.water_thr};
            REG_WATER_DEB: prdata = cfg_reg.water_deb;
            REG_PERSIST:   prdata = cfg_reg.persist;
            default:       prdata = 32'b0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/uofc_front.sv @@
`default_nettype none

module uofc_front import uofc_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [ECHO_W-1:0]  echo_one_us,
    input  wire logic [ECHO_W-1:0]  echo_two_us,
    input  wire logic [LEVEL_W-1:0] water_level,
    input  wire logic [TIME_W-1:0]  now_ms,
    output logic                    stg_valid,
    input  wire logic               stg_ready,
    output front_t                  stg
);

    // Echo time to Q8 distance, one constant multiply
    function automatic logic [DIST_W-1:0] echo_dist(input logic [ECHO_W-1:0] e);
        logic [DIST_PROD_W-1:0] p;
        p = {{(DIST_PROD_W-ECHO_W){1'b0}}, e} * {{(DIST_PROD_W-DIST_MULT_W){1'b0}}, DIST_MULT}
            + DIST_ROUND;
        return p[DIST_SHIFT +: DIST_W];
    endfunction

    function automatic logic echo_ok(input logic [ECHO_W-1:0] e);
        return (e != '0) && (e <= ECHO_TIMEOUT_US);
    endfunction

    logic               in_valid_reg;
    logic [ECHO_W-1:0]  echo_one_reg;
    logic [ECHO_W-1:0]  echo_two_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [TIME_W-1:0]  now_reg;
    logic               stg_valid_reg;
    front_t             stg_reg;
    logic               adv;

    assign adv       = !stg_valid_reg || stg_ready;
    assign in_ready  = !in_valid_reg || adv;
    assign stg_valid = stg_valid_reg;
    assign stg       = stg_reg;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            echo_one_reg <= echo_one_us;
            echo_two_reg <= echo_two_us;
            level_reg    <= water_level;
            now_reg      <= now_ms;
        end
    end

    // Distance stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else if (adv) begin
            stg_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && in_valid_reg) begin
            stg_reg.hv_one   <= echo_ok(echo_one_reg);
            stg_reg.hv_two   <= echo_ok(echo_two_reg);
            stg_reg.dist_one <= echo_dist(echo_one_reg);
            stg_reg.dist_two <= echo_dist(echo_two_reg);
            stg_reg.level    <= level_reg;
            stg_reg.now      <= now_reg;
        end
    end

endmodule

`default_nettype wire

@@ rtl/uofc_classify.sv @@
`default_nettype none

module uofc_classify import uofc_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire cfg_t   cfg,
    input  wire logic   stg_valid,
    output logic        stg_ready,
    input  wire front_t stg,
    output logic        out_valid,
    input  wire logic   out_ready,
    output result_t     res
);

    function automatic logic signed [HGT_W-1:0] cm_q8(input logic [CM_W-1:0] c);
        return $signed({2'b00, c, 8'b0});
    endfunction

    function automatic logic signed [Q8_W-1:0] q8_sat(input logic signed [HGT_W-1:0] h,
                                                     input logic v);
        logic signed [Q8_W-1:0] r;
        if (!v)
            r = '0;
        else if (h > Q8_MAX_EXT)
            r = Q8_MAX_EXT[Q8_W-1:0];
        else if (h < Q8_MIN_EXT)
            r = Q8_MIN_EXT[Q8_W-1:0];
        else
            r = h[Q8_W-1:0];
        return r;
    endfunction

    // Timer and lamp state
    logic              water_timing_reg, water_timing_next;
    logic [TIME_W-1:0] water_since_reg, water_since_next;
    logic [1:0]        lane_timing_reg, lane_timing_next;
    logic [TIME_W-1:0] lane_since_reg [2];
    logic [TIME_W-1:0] lane_since_next [2];
    logic [2:0]        lamp_reg, lamp_next;
    logic              out_valid_reg;
    result_t           res_reg;

    logic                     fire;
    logic signed [HGT_W-1:0]  h [2];
    logic [DIST_W-1:0]        dist_q8 [2];
    logic [1:0]               hv, obst, low, high, pers;
    logic [TIME_W-1:0]        lane_eff [2];
    logic                     raw_wet, wet;
    logic [TIME_W-1:0]        water_eff;
    logic                     both_obst, both_free, only_one;
    status_t                  code;

    assign stg_ready = !out_valid_reg || out_ready;
    assign fire      = stg_valid && stg_ready;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    assign hv         = {stg.hv_two, stg.hv_one};
    assign dist_q8[0] = stg.dist_one;
    assign dist_q8[1] = stg.dist_two;

    // Water debounce
    always_comb begin
        raw_wet   = stg.level > cfg.water_thr;
        water_eff = water_timing_reg ? water_since_reg : stg.now;
        wet       = raw_wet && ((stg.now - water_eff) >= cfg.water_deb);
        water_timing_next = water_timing_reg;
        water_since_next  = water_since_reg;
        if (fire) begin
            water_timing_next = raw_wet;
            water_since_next  = raw_wet ? water_eff : '0;
        end
    end

    // Per-lane height, thresholds and obstruction timer
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            h[i]        = cm_q8(cfg.mount) - $signed({1'b0, dist_q8[i]});
            obst[i]     = hv[i] && (h[i] > cm_q8(cfg.obst));
            low[i]      = obst[i] && (h[i] < cm_q8(cfg.low));
            high[i]     = obst[i] && (h[i] > cm_q8(cfg.high));
            lane_eff[i] = lane_timing_reg[i] ? lane_since_reg[i] : stg.now;
            pers[i]     = obst[i] && ((stg.now - lane_eff[i]) >= cfg.persist);
            lane_timing_next[i] = lane_timing_reg[i];
            lane_since_next[i]  = lane_since_reg[i];
            if (fire) begin
                lane_timing_next[i] = obst[i];
                lane_since_next[i]  = obst[i] ? lane_eff[i] : '0;
            end
        end
    end

    // Prioritized status
    always_comb begin
        both_obst = obst[0] && obst[1];
        both_free = !obst[0] && !obst[1];
        only_one  = obst[0] != obst[1];
        if (!hv[0] && !hv[1])
            code = ST_LOSS;
        else if (both_obst && low[0] && low[1] && wet)
            code = ST_FLOOD;
        else if (both_free && wet)
            code = ST_INCONS;
        else if (both_obst && low[0] && low[1] && pers[0] && pers[1])
            code = ST_SOLID;
        else if (both_obst && high[0] && high[1] && pers[0] && pers[1])
            code = ST_STOPPED;
        else if (only_one && ((high[0] && pers[0]) || (high[1] && pers[1])))
            code = ST_BLOCKED;
        else if (only_one && ((low[0] && pers[0]) || (low[1] && pers[1])))
            code = ST_ASYM;
        else if (only_one && ((high[0] && !pers[0]) || (high[1] && !pers[1])))
            code = ST_VEHICLE;
        else if (both_free)
            code = ST_NORMAL;
        else
            code = ST_NONE;
    end

    // Lamps hold when no rule matches
    always_comb begin
        lamp_next = lamp_reg;
        if (fire) begin
            case (code) inside
                ST_LOSS, ST_INCONS, ST_SOLID, ST_BLOCKED, ST_ASYM: lamp_next = LAMP_YELLOW;
                ST_FLOOD, ST_STOPPED:                              lamp_next = LAMP_RED;
                ST_VEHICLE, ST_NORMAL:                             lamp_next = LAMP_GREEN;
                default:                                           lamp_next = lamp_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            water_timing_reg  <= 1'b0;
            water_since_reg   <= '0;
            lane_timing_reg   <= '0;
            lane_since_reg[0] <= '0;
            lane_since_reg[1] <= '0;
            lamp_reg          <= LAMP_OFF;
            out_valid_reg     <= 1'b0;
        end else begin
            water_timing_reg  <= water_timing_next;
            water_since_reg   <= water_since_next;
            lane_timing_reg   <= lane_timing_next;
            lane_since_reg[0] <= lane_since_next[0];
            lane_since_reg[1] <= lane_since_next[1];
            lamp_reg          <= lamp_next;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg.status <= code;
            res_reg.green  <= lamp_next[0];
            res_reg.yellow <= lamp_next[1];
            res_reg.red    <= lamp_next[2];
            res_reg.h_one  <= q8_sat(h[0], hv[0]);
            res_reg.hv_one <= hv[0];
            res_reg.h_two  <= q8_sat(h[1], hv[1]);
            res_reg.hv_two <= hv[1];
            res_reg.wet    <= wet;
        end
    end

endmodule

`default_nettype wire

@@ rtl/underpass_obstruction_flood_classifier_unit.sv @@
// A word accepted on s_ passes the input register, the distance multiply stage,
// the classifier and the result register before it appears on m_.
// Throughput: one word per cycle; each stage stalls only when the one after it is full.
// The classifier timers and lamps update once per word, in order, at the result register.
// Reset (aresetn low, synchronous) empties the pipeline, clears timers and lamps
// and loads register defaults.
`default_nettype none

module underpass_obstruction_flood_classifier_unit import uofc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: echo_one_us[14:0], echo_two_us[29:15], water_level[41:30], now_ms[73:42]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,
    // m_tdata: status_code[3:0], lamp_green[4], lamp_yellow[5], lamp_red[6],
    // height_one_q8[24:7], height_one_valid[25], height_two_q8[43:26],
    // height_two_valid[44], water_confirmed[45]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t    cfg;
    front_t  stg;
    logic    stg_valid;
    logic    stg_ready;
    result_t res;

    uofc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    uofc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .echo_one_us (s_tdata[14:0]),
        .echo_two_us (s_tdata[29:15]),
        .water_level (s_tdata[41:30]),
        .now_ms      (s_tdata[73:42]),
        .stg_valid   (stg_valid),
        .stg_ready   (stg_ready),
        .stg         (stg)
    );

    uofc_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .stg_valid (stg_valid),
        .stg_ready (stg_ready),
        .stg       (stg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res       (res)
    );

    // Pack result word
    assign m_tdata = {2'b00, res.wet, res.hv_two, res.h_two, res.hv_one, res.h_one,
                      res.red, res.yellow, res.green, res.status};

    // At most one lamp lit
    a_lamp_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0(m_tdata[6:4]))
        else $error("more than one lamp lit");

    // Missing lane one reading gives a zero lane one height
    a_h_one_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[25]) |-> (m_tdata[24:7] == '0))
        else $error("lane one height without reading");

    // Signal loss exactly when neither lane reads
    a_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[3:0] == ST_LOSS) == (!m_tdata[25] && !m_tdata[44])))
        else $error("signal loss code mismatch");

    // Normal traffic shows green
    a_normal_green: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[3:0] == ST_NORMAL)) |-> (m_tdata[6:4] == LAMP_GREEN))
        else $error("normal status without green lamp");

endmodule

`default_nettype wire

@@ test/tb_underpass_obstruction_flood_classifier_unit.sv @@
module tb_underpass_obstruction_flood_classifier_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import uofc_pkg::*;

    // Echo to Q8 distance: dist = (echo * 43904 + 5000) / 10000
    localparam longint unsigned ECHO_Q8_NUM = 43904;
    localparam longint unsigned ECHO_Q8_DEN = 10000;
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;   // unmapped register slot
    localparam int PIPE_LATENCY = 3;
    localparam int CYCLE_LIMIT  = 400000;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    // s_tdata: echo_one_us[14:0], echo_two_us[29:15], water_level[41:30], now_ms[73:42]
    logic [79:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    // m_tdata: status_code[3:0], lamp_green[4], lamp_yellow[5], lamp_red[6],
    // height_one_q8[24:7], height_one_valid[25], height_two_q8[43:26],
    // height_two_valid[44], water_confirmed[45]
    logic [47:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    underpass_obstruction_flood_classifier_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow of the classifier: registers, timers and lamps
    cfg_t             shadow;
    bit               water_armed;
    logic [TIME_W-1:0] water_start;
    bit               lane_armed [2];
    logic [TIME_W-1:0] lane_start [2];
    logic [2:0]       lamps;

    result_t report_q [$];   // predicted result words, oldest first

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int mismatches    = 0;
    int words_sent    = 0;
    int words_checked = 0;
    int settings_loaded = 0;
    int cycle_count   = 0;

    // Exact Q8 height of a lane for a valid echo
    function automatic int lane_height_q8(input logic [ECHO_W-1:0] echo);
        longint unsigned dist_q8;
        dist_q8 = (longint'(echo) * ECHO_Q8_NUM + ECHO_Q8_DEN / 2) / ECHO_Q8_DEN;
        return int'(shadow.mount) * 256 - int'(dist_q8);
    endfunction

    // Advances the shadow by one sample and returns the expected result word
    function automatic result_t classify_sample(input logic [ECHO_W-1:0] echo_one,
            input logic [ECHO_W-1:0] echo_two, input logic [LEVEL_W-1:0] level,
            input logic [TIME_W-1:0] now);
        logic [ECHO_W-1:0] echo [2];
        bit seen [2], obst [2], low [2], high [2], held [2];
        int hgt [2];
        int sat;
        logic signed [Q8_W-1:0] hq [2];
        logic [TIME_W-1:0] elapsed;
        bit wet, both_obst, both_free, one_only;
        status_t code;
        result_t r;

        echo[0] = echo_one;
        echo[1] = echo_two;

        // water debounce
        if (level > shadow.water_thr) begin
            if (!water_armed) begin
                water_armed = 1'b1;
                water_start = now;
            end
            elapsed = now - water_start;
            wet = elapsed >= shadow.water_deb;
        end else begin
            water_armed = 1'b0;
            water_start = '0;
            wet = 1'b0;
        end

        // per-lane height, obstruction timer and height classes
        for (int i = 0; i < 2; i++) begin
            seen[i] = echo[i] != '0 && echo[i] <= ECHO_TIMEOUT_US;
            hgt[i] = seen[i] ? lane_height_q8(echo[i]) : 0;
            obst[i] = seen[i] && hgt[i] > int'(shadow.obst) * 256;
            if (obst[i]) begin
                if (!lane_armed[i]) begin
                    lane_armed[i] = 1'b1;
                    lane_start[i] = now;
                end
                elapsed = now - lane_start[i];
                held[i] = elapsed >= shadow.persist;
            end else begin
                lane_armed[i] = 1'b0;
                lane_start[i] = '0;
                held[i] = 1'b0;
            end
            low[i]  = obst[i] && hgt[i] < int'(shadow.low) * 256;
            high[i] = obst[i] && hgt[i] > int'(shadow.high) * 256;
            sat = hgt[i] > int'(Q8_MAX_EXT) ? int'(Q8_MAX_EXT) :
                  hgt[i] < int'(Q8_MIN_EXT) ? int'(Q8_MIN_EXT) : hgt[i];
            hq[i] = seen[i] ? Q8_W'(sat) : '0;
        end

        both_obst = obst[0] && obst[1];
        both_free = !obst[0] && !obst[1];
        one_only  = obst[0] != obst[1];

        // prioritized status
        if (!seen[0] && !seen[1])
            code = ST_LOSS;
        else if (both_obst && low[0] && low[1] && wet)
            code = ST_FLOOD;
        else if (both_free && wet)
            code = ST_INCONS;
        else if (both_obst && low[0] && low[1] && held[0] && held[1])
            code = ST_SOLID;
        else if (both_obst && high[0] && high[1] && held[0] && held[1])
            code = ST_STOPPED;
        else if (one_only && ((high[0] && held[0]) || (high[1] && held[1])))
            code = ST_BLOCKED;
        else if (one_only && ((low[0] && held[0]) || (low[1] && held[1])))
            code = ST_ASYM;
        else if (one_only && ((high[0] && !held[0]) || (high[1] && !held[1])))
            code = ST_VEHICLE;
        else if (both_free)
            code = ST_NORMAL;
        else
            code = ST_NONE;

        // lamps hold on no match
        case (code)
            ST_LOSS, ST_INCONS, ST_SOLID, ST_BLOCKED, ST_ASYM: lamps = LAMP_YELLOW;
            ST_FLOOD, ST_STOPPED:                              lamps = LAMP_RED;
            ST_VEHICLE, ST_NORMAL:                             lamps = LAMP_GREEN;
            default: ;
        endcase

        r.status = code;
        r.green  = lamps[0];
        r.yellow = lamps[1];
        r.red    = lamps[2];
        r.h_one  = hq[0];
        r.hv_one = seen[0];
        r.h_two  = hq[1];
        r.hv_two = seen[1];
        r.wet    = wet;
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Result checker and receiver stalls
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (report_q.size() == 0) begin
                $error("result word with no prediction pending: %h", m_tdata);
                mismatches++;
            end else begin
                want = report_q.pop_front();
                check_field("status_code", want.status, m_tdata[3:0]);
                check_field("lamp_green", want.green, m_tdata[4]);
                check_field("lamp_yellow", want.yellow, m_tdata[5]);
                check_field("lamp_red", want.red, m_tdata[6]);
                check_field("height_one_q8", want.h_one, $signed(m_tdata[24:7]));
                check_field("height_one_valid", want.hv_one, m_tdata[25]);
                check_field("height_two_q8", want.h_two, $signed(m_tdata[43:26]));
                check_field("height_two_valid", want.hv_two, m_tdata[44]);
                check_field("water_confirmed", want.wet, m_tdata[45]);
                words_checked++;
            end
        end
        m_tready <= aresetn ? ($urandom_range(0, 99) >= stall_pct) : 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Sends one sample word; prediction is made at acceptance
    task automatic send_sample(input logic [ECHO_W-1:0] echo_one,
            input logic [ECHO_W-1:0] echo_two, input logic [LEVEL_W-1:0] level,
            input logic [TIME_W-1:0] now);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, now, level, echo_two, echo_one};
        do @(posedge aclk); while (!s_tready);
        report_q.push_back(classify_sample(echo_one, echo_two, level, now));
        words_sent++;
    endtask

    // Stop sending and let the pipeline empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (report_q.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_MOUNT:     shadow.mount     = data[CM_W-1:0];
            REG_OBST:      shadow.obst      = data[CM_W-1:0];
            REG_LOW:       shadow.low       = data[CM_W-1:0];
            REG_HIGH:      shadow.high      = data[CM_W-1:0];
            REG_WATER_THR: shadow.water_thr = data[LEVEL_W-1:0];
            REG_WATER_DEB: shadow.water_deb = data;
            REG_PERSIST:   shadow.persist   = data;
            default: ;
        endcase
    endtask

    // Loads a full register set; upper bits of narrow registers may carry junk
    task automatic load_settings(input cfg_t c);
        logic [31:0] junk;
        wait_idle();
        junk = $urandom_range(0, 1) ? $urandom : 32'd0;
        write_reg(REG_MOUNT, {junk[31:CM_W], c.mount});
        write_reg(REG_OBST, {junk[31:CM_W], c.obst});
        write_reg(REG_LOW, {junk[31:CM_W], c.low});
        write_reg(REG_HIGH, {junk[31:CM_W], c.high});
        write_reg(REG_WATER_THR, {junk[31:LEVEL_W], c.water_thr});
        write_reg(REG_WATER_DEB, c.water_deb);
        write_reg(REG_PERSIST, c.persist);
        write_reg(REG_SPARE, $urandom);
        settings_loaded++;
    endtask

    // Walk through every status code with reset register values.
    // Rough echoes at 150 cm mount: 1749 -> 120 cm, 4373 -> 75 cm,
    // 7580 -> 20 cm, 9000 -> road level.
    task automatic test_status_codes();
        send_sample(15'd0, 15'd0, 12'd0, 32'd0);                    // no reading
        send_sample(15'd30001, 15'd32767, 12'd4095, 32'd1);         // past timeout
        send_sample(15'd9000, 15'd9000, 12'd0, 32'd2);              // normal
        // lane timer started at time zero, then persistent
        send_sample(15'd1749, 15'd9000, 12'd0, 32'd0);
        send_sample(15'd1749, 15'd9000, 12'd0, 32'd60000);
        // one low lane, new then persistent
        send_sample(15'd9000, 15'd7580, 12'd0, 32'd60001);
        send_sample(15'd9000, 15'd7580, 12'd0, 32'd120001);
        // both low, then solid, then both high while timers keep running
        send_sample(15'd7580, 15'd7580, 12'd0, 32'd120002);
        send_sample(15'd7580, 15'd7580, 12'd0, 32'd180002);
        send_sample(15'd1749, 15'd1749, 12'd0, 32'd180003);
        send_sample(15'd4373, 15'd4373, 12'd0, 32'd180004);          // no rule, lamps hold
        // water rises on low obstructions, then on a clear road
        send_sample(15'd7580, 15'd7580, 12'd4095, 32'd180005);
        send_sample(15'd7580, 15'd7580, 12'd4095, 32'd200005);
        send_sample(15'd9000, 15'd9000, 12'd4095, 32'd200006);
        // water debounce across the timestamp wrap
        send_sample(15'd9000, 15'd9000, 12'd2000, 32'hFFFF_F000);
        send_sample(15'd9000, 15'd9000, 12'd2001, 32'hFFFF_F000);
        send_sample(15'd9000, 15'd9000, 12'd2001, 32'h0000_4000);
        send_sample(15'd30000, 15'd1, 12'd4095, 32'h0000_4001);
    endtask

    // Register extremes: all max, all zero, and a mix that makes every lane persist
    task automatic test_register_extremes();
        cfg_t c;
        c = '{mount: '1, obst: '1, low: '1, high: '1, water_thr: '1,
              water_deb: '1, persist: '1};
        load_settings(c);
        send_sample(15'd1, 15'd1, 12'd4095, 32'd0);
        send_sample(15'd30000, 15'd30000, 12'd0, 32'd5);
        c = '0;
        load_settings(c);
        send_sample(15'd30000, 15'd30000, 12'd1, 32'd0);             // heights saturate low
        send_sample(15'd1, 15'd30000, 12'd4095, 32'd7);
        c = '{mount: '1, obst: '0, low: '1, high: '0, water_thr: 12'd2000,
              water_deb: '0, persist: '0};
        load_settings(c);
        send_sample(15'd1, 15'd1, 12'd0, 32'd9);
        send_sample(15'd1, 15'd0, 12'd4095, 32'd10);
    endtask

    // Random runs of steady lane heights and water levels, with some noise words
    task automatic test_random_traffic();
        cfg_t c;
        int window, run_left, h_cm, jit;
        longint e;
        logic [TIME_W-1:0] now;
        logic [ECHO_W-1:0] base [2];
        logic [ECHO_W-1:0] echo [2];
        bit fixed [2];
        bit wet_run;
        logic [LEVEL_W-1:0] level;
        for (int mode = 0; mode < 4; mode++) begin
            send_idle_pct = (mode == 1) ? 61 : (mode == 3) ? 38 : 0;
            stall_pct     = (mode == 2) ? 61 : (mode == 3) ? 38 : 0;
            for (int k = 0; k < 3; k++) begin
                // ordered thresholds so every height class is reachable
                window      = $urandom_range(1, 3000);
                c.mount     = CM_W'($urandom_range(40, 511));
                c.obst      = CM_W'($urandom_range(0, c.mount / 8));
                c.low       = CM_W'($urandom_range(c.obst, c.mount / 2));
                c.high      = CM_W'($urandom_range(c.low, c.mount));
                c.water_thr = LEVEL_W'($urandom_range(0, 4095));
                c.water_deb = $urandom_range(0, 3 * window);
                c.persist   = $urandom_range(0, 3 * window);
                if ($urandom_range(0, 5) == 0)
                    c.water_deb = $urandom_range(0, 1) ? '1 : '0;
                if ($urandom_range(0, 5) == 0)
                    c.persist = $urandom_range(0, 1) ? '1 : '0;
                load_settings(c);
                now = $urandom;
                run_left = 0;
                for (int n = 0; n < 38; n++) begin
                    if (run_left == 0) begin
                        run_left = $urandom_range(1, 12);
                        wet_run = $urandom_range(0, 1) && c.water_thr != '1;
                        for (int i = 0; i < 2; i++) begin
                            fixed[i] = 1'b1;
                            case ($urandom_range(0, 9))
                                0: base[i] = '0;
                                1: base[i] = ECHO_W'($urandom_range(ECHO_TIMEOUT_US + 1, 32767));
                                default: begin
                                    h_cm = int'($urandom_range(0, c.mount + 10)) - 10;
                                    e = longint'((longint'(int'(c.mount) - h_cm) * 256
                                        * ECHO_Q8_DEN + ECHO_Q8_NUM / 2) / ECHO_Q8_NUM);
                                    if (e < 1)
                                        e = 1;
                                    if (e > ECHO_TIMEOUT_US)
                                        e = ECHO_TIMEOUT_US;
                                    base[i] = ECHO_W'(e);
                                    fixed[i] = 1'b0;
                                end
                            endcase
                        end
                    end
                    run_left--;
                    if ($urandom_range(0, 7) == 0) begin
                        // noise word
                        echo[0] = ECHO_W'($urandom);
                        echo[1] = ECHO_W'($urandom);
                        level   = LEVEL_W'($urandom);
                    end else begin
                        for (int i = 0; i < 2; i++) begin
                            jit = int'(base[i]) + int'($urandom_range(0, 8)) - 4;
                            if (jit < 1)
                                jit = 1;
                            if (jit > int'(ECHO_TIMEOUT_US))
                                jit = int'(ECHO_TIMEOUT_US);
                            echo[i] = fixed[i] ? base[i] : ECHO_W'(jit);
                        end
                        if ($urandom_range(0, 19) == 0)
                            level = LEVEL_W'($urandom);
                        else if (wet_run)
                            level = LEVEL_W'($urandom_range(c.water_thr + 1, 4095));
                        else
                            level = LEVEL_W'($urandom_range(0, c.water_thr));
                    end
                    now = now + $urandom_range(0, window);
                    send_sample(echo[0], echo[1], level, now);
                end
            end
        end
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;

        // shadow reset state
        shadow = '{mount: RST_MOUNT, obst: RST_OBST, low: RST_LOW, high: RST_HIGH,
                   water_thr: RST_WATER_THR, water_deb: RST_WATER_DEB,
                   persist: RST_PERSIST};
        water_armed = 1'b0;
        water_start = '0;
        lane_armed  = '{1'b0, 1'b0};
        lane_start  = '{'0, '0};
        lamps       = LAMP_OFF;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_status_codes();
        test_register_extremes();
        test_random_traffic();
        wait_idle();

        $display("Checked %0d result words for %0d sample words over %0d register sets",
                 words_checked, words_sent, settings_loaded);
        $display("Pacing: free running, sender gaps, receiver stalls, and both at once");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
